### rtl/core/bsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline basis package
// Shared widths, constants and operation codes of the basis evaluator.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int unsigned MaxKnots  = 32;
  localparam int unsigned MaxDegree = 7;
  localparam int unsigned ValW      = 24;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned DegW      = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 5;

  localparam logic [ValW-1:0] OneQ23 = 24'd8388608;

  // input operations
  localparam logic OpWrite = 1'b0;
  localparam logic OpEval  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDegree  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNumCtrl = 1'd1;

endpackage
`default_nettype wire

### rtl/core/bsb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline basis channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface bsb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bsb_pkg::IdxW-1:0]      knot_index;
  logic [bsb_pkg::ValW-1:0]      value;
  modport source (output valid, op, knot_index, value, input ready);
  modport sink   (input valid, op, knot_index, value, output ready);
endinterface

interface bsb_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsb_pkg::IdxW-1:0]      ctrl_index;
  logic [bsb_pkg::ValW-1:0]      basis_value;
  logic                          last;
  modport source (output valid, ctrl_index, basis_value, last, input ready);
  modport sink   (input valid, ctrl_index, basis_value, last, output ready);
endinterface

interface bsb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsb_pkg::CfgIdxW-1:0]   index;
  logic [bsb_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/bspline_basis_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline basis evaluator
// Knot table plus span search and Cox-de Boor recurrence on one shared
// multiplier and one radix-2 restoring divider.
// ----------------------------------------------------------------------------
// Sequence: evaluation runs a span search by bisection, then two knot reads
//   per row j, then per recurrence cell two halves (setup, multiply, 50-step
//   divide, round, accumulate), p*(p+1)/2 cells, then p+1 result transfers.
// Throughput: one item at a time, set by the bit-serial divider loop.
// Reset: degree 3, num_ctrl 8, idle; knot table holds no reset value.
module bspline_basis_evaluator (
  input  wire            clk_i,
  input  wire            rst_ni,
  bsb_cfg_if.sink        cfg_i,
  bsb_in_if.sink         in_i,
  bsb_out_if.source      out_o
);

  localparam int unsigned VW = bsb_pkg::ValW;
  localparam int unsigned IW = bsb_pkg::IdxW;
  localparam int unsigned PW = 2*VW + 2;   // product magnitude width (50)
  localparam int unsigned DW = VW + 2;     // divisor magnitude width
  localparam int unsigned CW = $clog2(PW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LIM, S_CHKN, S_CHKP, S_MID, S_CMP1, S_CMP2,
    S_LR, S_CELL, S_MUL, S_DIV, S_ACC, S_NEXT, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [bsb_pkg::DegW-1:0] degree_q;
  logic [IW-1:0]            num_ctrl_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q   <= 3'd3;
      num_ctrl_q <= 5'd8;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bsb_pkg::CfgDegree:  degree_q   <= cfg_i.data[bsb_pkg::DegW-1:0];
        bsb_pkg::CfgNumCtrl: num_ctrl_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // knot memory, one read port registered
  logic [VW-1:0] knot_mem [bsb_pkg::MaxKnots];
  logic [IW-1:0] rd_addr;
  logic [VW-1:0] knot_rd_q;
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready && in_i.op == bsb_pkg::OpWrite)
      knot_mem[in_i.knot_index] <= in_i.value;
    knot_rd_q <= knot_mem[rd_addr];
  end

  // working registers
  logic [VW-1:0]     u_q;
  logic [2:0]        p_q;
  logic [IW:0]       n_q, lo_q, hi_q, mid_q, span_q;
  logic [2:0]        j_q, r_q, sub_q;
  logic [VW:0]       left_q  [bsb_pkg::MaxDegree+1];
  logic [VW:0]       right_q [bsb_pkg::MaxDegree+1];
  logic [VW-1:0]     ndu_q   [bsb_pkg::MaxDegree+1];
  logic signed [PW+1:0] saved_q, a_q;   // full quotient range before saturation
  logic              half_q;        // which product: 0 right, 1 left
  logic signed [VW:0] mulx_q;
  logic signed [DW-1:0] den_q;
  logic [PW-1:0]     num_q, quo_q;
  logic [DW-1:0]     rem_q, dmag_q;
  logic [CW-1:0]     cnt_q;
  logic              neg_q;

  // clamped degree and control count
  logic [2:0] p_eff;
  logic [IW:0] n_eff, n_lo, n_hi;
  always_comb begin
    p_eff = (degree_q == 3'd0) ? 3'd1 : degree_q;
    n_lo  = {3'd0, p_eff} + 6'd1;
    n_hi  = 6'(bsb_pkg::MaxKnots) - {3'd0, p_eff} - 6'd1;
    n_eff = {1'b0, num_ctrl_q};
    if (n_eff < n_lo) n_eff = n_lo;
    if (n_eff > n_hi) n_eff = n_hi;
  end

  // read address select
  logic [IW:0] kaddr;
  always_comb begin
    unique case (state_q)
      S_LIM:   kaddr = n_q;
      S_CHKN:  kaddr = {3'd0, p_q};
      S_MID:   kaddr = (lo_q + hi_q) >> 1;
      S_CMP1:  kaddr = mid_q + 6'd1;
      S_NEXT:  kaddr = span_q + 6'd1 - {3'd0, j_q};
      S_LR:    kaddr = span_q + {3'd0, j_q};
      default: kaddr = span_q;
    endcase
    rd_addr = kaddr[IW-1:0];
  end

  // shared multiplier operand and denominator
  logic signed [VW:0]   rsel, lsel;
  logic signed [DW-1:0] den_d;
  always_comb begin
    rsel  = signed'(right_q[r_q + 3'd1]);
    lsel  = signed'(left_q[j_q - r_q]);
    den_d = DW'(rsel) + DW'(lsel);
  end
  logic signed [PW:0] prod;
  assign prod = (PW+1)'(mulx_q) * signed'({1'b0, ndu_q[r_q]});

  // divider trial subtract
  logic [DW:0] trial;
  assign trial = {rem_q, num_q[PW-1]} - {1'b0, dmag_q};

  logic [PW+2:0] sum_v;
  logic [VW-1:0] sat_sum;
  always_comb begin
    sum_v = (PW+3)'(saved_q) + (PW+3)'(a_q);
    if (sum_v[PW+2])            sat_sum = '0;
    else if (sum_v > (PW+3)'(bsb_pkg::OneQ23)) sat_sum = bsb_pkg::OneQ23;
    else                        sat_sum = sum_v[VW-1:0];
  end
  logic [VW-1:0] sat_saved;
  always_comb begin
    if (saved_q < 0) sat_saved = '0;
    else if (saved_q > (PW+2)'(bsb_pkg::OneQ23)) sat_saved = bsb_pkg::OneQ23;
    else sat_saved = saved_q[VW-1:0];
  end

  assign in_i.ready = (state_q == S_IDLE);
  // row tail cycles (r_q nonzero) carry no result
  assign out_o.valid = (state_q == S_OUT) && (r_q == '0);
  assign out_o.ctrl_index = IW'(span_q - {3'd0, p_q} + {3'd0, j_q});
  assign out_o.basis_value = ndu_q[j_q];
  assign out_o.last = (j_q == p_q);

  logic signed [PW+1:0] qround;
  assign qround = neg_q ? -(PW+2)'(quo_q) : (PW+2)'(quo_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q <= '0; r_q <= '0; sub_q <= '0; half_q <= 1'b0; cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_i.valid && in_i.op == bsb_pkg::OpEval) begin
          u_q <= in_i.value; p_q <= p_eff; n_q <= n_eff;
          lo_q <= {3'd0, p_eff}; hi_q <= n_eff;
          state_q <= S_LIM;
        end
        S_LIM: state_q <= S_CHKN;
        S_CHKN: if (u_q >= knot_rd_q) begin
          span_q <= n_q - 6'd1; state_q <= S_LR; j_q <= 3'd1; sub_q <= 3'd0;
        end else state_q <= S_CHKP;
        S_CHKP: if (u_q <= knot_rd_q) begin
          span_q <= lo_q; state_q <= S_LR; j_q <= 3'd1; sub_q <= 3'd0;
        end else state_q <= S_MID;
        S_MID: if (hi_q - lo_q <= 6'd1) begin
          span_q <= lo_q; state_q <= S_LR; j_q <= 3'd1; sub_q <= 3'd0;
        end else begin
          mid_q <= kaddr; state_q <= S_CMP1;
        end
        S_CMP1: if (u_q < knot_rd_q) begin
          hi_q <= mid_q; state_q <= S_MID;
        end else state_q <= S_CMP2;
        S_CMP2: if (u_q >= knot_rd_q) begin
          lo_q <= mid_q; state_q <= S_MID;
        end else begin
          span_q <= mid_q; state_q <= S_LR; j_q <= 3'd1; sub_q <= 3'd0;
        end
        // two knot reads per j: right then left
        S_LR: begin
          if (j_q == 3'd1 && sub_q == 3'd0) begin
            ndu_q[0] <= bsb_pkg::OneQ23;
          end
          if (sub_q == 3'd0) sub_q <= 3'd1;
          else if (sub_q == 3'd1) begin
            right_q[j_q] <= {1'b0, knot_rd_q} - {1'b0, u_q};
            sub_q <= 3'd2; state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (sub_q == 3'd2) sub_q <= 3'd3;
          else begin
            left_q[j_q] <= {1'b0, u_q} - {1'b0, knot_rd_q};
            r_q <= '0; saved_q <= '0; half_q <= 1'b0; state_q <= S_CELL;
          end
        end
        S_CELL: begin
          den_q  <= den_d;
          mulx_q <= half_q ? lsel : rsel;
          state_q <= S_MUL;
        end
        S_MUL: begin
          neg_q  <= prod[PW] ^ den_q[DW-1];
          num_q  <= prod[PW] ? PW'(-prod) : prod[PW-1:0];
          dmag_q <= den_q[DW-1] ? DW'(-den_q) : den_q;
          rem_q  <= '0; quo_q <= '0; cnt_q <= CW'(PW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dmag_q == '0) begin
            quo_q <= '0; neg_q <= 1'b0; state_q <= S_ACC;
          end else if (cnt_q != '0) begin
            if (!trial[DW]) begin
              rem_q <= trial[DW-1:0]; quo_q <= {quo_q[PW-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[DW-2:0], num_q[PW-1]}; quo_q <= {quo_q[PW-2:0], 1'b0};
            end
            num_q <= {num_q[PW-2:0], 1'b0};
            cnt_q <= cnt_q - CW'(1);
          end else begin
            // round half away: bump if 2*rem >= den
            if ({rem_q, 1'b0} >= {1'b0, dmag_q}) quo_q <= quo_q + PW'(1);
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (!half_q) begin
            a_q <= qround; half_q <= 1'b1; state_q <= S_CELL;
          end else begin
            ndu_q[r_q] <= sat_sum;
            saved_q <= qround; half_q <= 1'b0;
            if (r_q + 3'd1 == j_q) begin
              state_q <= S_OUT;
              r_q <= j_q;
            end else begin
              r_q <= r_q + 3'd1; state_q <= S_CELL;
            end
          end
        end
        S_OUT: begin
          if (r_q != '0) begin
            // finishing a row: store its tail then move on
            ndu_q[j_q] <= sat_saved;
            r_q <= '0;
            if (j_q == p_q) j_q <= '0;
            else begin
              j_q <= j_q + 3'd1; sub_q <= 3'd0; state_q <= S_LR;
            end
          end else if (out_o.ready) begin
            if (j_q == p_q) state_q <= S_IDLE;
            else j_q <= j_q + 3'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
